### hdl/cbm_pkg.sv
// Shared types, widths and address codes of the cartridge bank mapper.
package cbm_pkg;

    // Field widths.
    localparam int OP_W       = 3;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int LINE_W     = 9;
    localparam int ROM_W      = 21;
    localparam int MIRROR_W   = 2;
    localparam int PRG_CNT_W  = 8;
    localparam int CHR_CNT_W  = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Bank arithmetic widths.
    localparam int BANK_W     = 11;
    localparam int PRG_OFS_W  = 13;
    localparam int CHR_OFS_W  = 10;

    // Expansion RAM.
    localparam int XRAM_DEPTH = 1024;
    localparam int XRAM_AW    = $clog2(XRAM_DEPTH);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_READ  = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd2;
    localparam logic [OP_W-1:0] OP_PRG   = 3'd3;
    localparam logic [OP_W-1:0] OP_CHR   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_RAM   = 2'd2;

    // Register window addresses.
    localparam logic [ADDR_W-1:0] A_XRAM_BASE = 16'h5C00;
    localparam logic [ADDR_W-1:0] A_PRG_MODE  = 16'h5100;
    localparam logic [ADDR_W-1:0] A_CHR_MODE  = 16'h5101;
    localparam logic [ADDR_W-1:0] A_NT_SEL    = 16'h5105;
    localparam logic [ADDR_W-1:0] A_PRG_BANK  = 16'h5114;
    localparam logic [ADDR_W-1:0] A_SPR_BANK  = 16'h5120;
    localparam logic [ADDR_W-1:0] A_BG_BANK   = 16'h5128;
    localparam logic [ADDR_W-1:0] A_IRQ_LINE  = 16'h5203;
    localparam logic [ADDR_W-1:0] A_IRQ_STAT  = 16'h5204;
    localparam logic [ADDR_W-1:0] A_MUL_LO    = 16'h5205;
    localparam logic [ADDR_W-1:0] A_MUL_HI    = 16'h5206;

    // Nametable select patterns and mirroring codes.
    localparam logic [DATA_W-1:0] NT_HORIZ  = 8'h50;
    localparam logic [DATA_W-1:0] NT_VERT   = 8'h44;
    localparam logic [DATA_W-1:0] NT_SINGLE_B = 8'h55;
    localparam logic [MIRROR_W-1:0] MIR_SINGLE_A = 2'd0;
    localparam logic [MIRROR_W-1:0] MIR_HORIZ    = 2'd1;
    localparam logic [MIRROR_W-1:0] MIR_VERT     = 2'd2;
    localparam logic [MIRROR_W-1:0] MIR_SINGLE_B = 2'd3;

    // First scanline outside the visible frame.
    localparam logic [LINE_W-1:0] FRAME_END = 9'd240;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic [LINE_W-1:0] scanline;
        logic              background_fetch;
    } req_word_t;

    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic                irq_line;
        logic [ROM_W-1:0]    rom_address;
        logic                rom_valid;
        logic [MIRROR_W-1:0] mirroring;
    } rsp_word_t;

    // Request to the remainder unit.
    typedef struct packed {
        logic                 start;
        logic [BANK_W-1:0]    dividend;
        logic [CHR_CNT_W-1:0] divisor;
    } mod_req_t;

    // Status from the remainder unit.
    typedef struct packed {
        logic                 done;
        logic [CHR_CNT_W-1:0] remainder;
    } mod_rsp_t;

endpackage

### hdl/cbm_if.sv
// Valid/ready channel interfaces for request and response words.
interface cbm_req_if;
    import cbm_pkg::*;
    logic      valid;
    logic      ready;
    req_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cbm_rsp_if;
    import cbm_pkg::*;
    logic      valid;
    logic      ready;
    rsp_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/cbm_mod.sv
// Bit-serial restoring remainder unit for bank numbers modulo a bank count.
module cbm_mod (
    input  logic              clk,
    input  logic              rst_n,
    input  cbm_pkg::mod_req_t req,
    output cbm_pkg::mod_rsp_t rsp
);
    import cbm_pkg::*;

    localparam int CNT_W = $clog2(BANK_W);

    logic                 active_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [BANK_W-1:0]    dvd_reg;
    logic [CHR_CNT_W-1:0] dvs_reg;
    logic [CHR_CNT_W-1:0] rem_reg;
    logic [CHR_CNT_W:0]   trial;
    logic [CHR_CNT_W:0]   diff;
    logic [CHR_CNT_W-1:0] rem_next;

    // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[BANK_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = diff[CHR_CNT_W-1:0];
        end
        else
        begin
            rem_next = trial[CHR_CNT_W-1:0];
        end
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                active_reg <= 1'b1;
                count_reg  <= CNT_W'(BANK_W - 1);
            end
            else if (active_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == '0)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (active_reg)
        begin
            dvd_reg <= {dvd_reg[BANK_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

### hdl/cartridge_bank_mapper_irq_core.sv
// Cartridge bank mapper core: register window, expansion RAM, scanline IRQ and translation.
// Each request word runs through a small sequencer. Reads, writes, scanline ticks and
// translations that miss pass from acceptance through the execute and finish states to the
// response register; a translation that hits ROM also waits in the divide state, since the
// bank number is reduced modulo the bank count by a shared remainder unit that retires one
// bit per cycle over eleven bits. The next request is taken once the previous word has
// reached the response register. After reset the block zeroes the expansion RAM, one byte
// a cycle, and takes no request meanwhile; configuration writes are taken at any time.
module cartridge_bank_mapper_irq_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]   cfg_data,
    cbm_req_if.sink                          request,
    cbm_rsp_if.source                        response
);
    import cbm_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    // Configuration.
    logic [PRG_CNT_W-1:0] prg_count_reg;
    logic [CHR_CNT_W-1:0] chr_count_reg;
    logic                 chr_ram_reg;

    // Mapper registers.
    logic [1:0]        prg_mode_reg;
    logic [1:0]        chr_mode_reg;
    logic [DATA_W-1:0] prg_bank_reg [4];
    logic [DATA_W-1:0] spr_bank_reg [8];
    logic [DATA_W-1:0] bg_bank_reg  [4];
    logic [DATA_W-1:0] nt_sel_reg;
    logic [DATA_W-1:0] mul_a_reg;
    logic [DATA_W-1:0] mul_b_reg;
    logic [DATA_W-1:0] irq_line_reg;
    logic              irq_enable_reg;
    logic              irq_pending_reg;
    logic              irq_out_reg;
    logic              frame_active_reg;

    // Sequencer and work registers.
    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [XRAM_AW-1:0] clr_idx_reg;
    req_word_t          item_reg;
    logic [DATA_W-1:0]  rd_reg;
    logic [ROM_W-1:0]   rom_reg;
    logic               rom_valid_reg;
    logic               rsp_valid_reg;
    rsp_word_t          rsp_data_reg;

    // Expansion RAM.
    logic [DATA_W-1:0]  xram [XRAM_DEPTH];
    logic [DATA_W-1:0]  xram_q;
    logic               xram_we;
    logic [XRAM_AW-1:0] xram_waddr;
    logic [DATA_W-1:0]  xram_wdata;

    // Decode and datapath.
    logic [ADDR_W-1:0]     addr;
    logic                  xram_hit;
    logic [1:0]            prg_slot;
    logic [2:0]            chr_slot;
    logic [6:0]            prg_bank;
    logic [BANK_W-1:0]     spr_bank;
    logic [BANK_W-1:0]     bg_bank;
    logic [2*DATA_W-1:0]   product;
    logic                  prg_go;
    logic                  chr_go;
    logic [MIRROR_W-1:0]   mirror_code;
    logic                  rsp_free;
    mod_req_t              mod_req;
    mod_rsp_t              mod_rsp;

    assign addr     = item_reg.address;
    assign xram_hit = (addr[ADDR_W-1:XRAM_AW] == A_XRAM_BASE[ADDR_W-1:XRAM_AW]);
    assign prg_slot = addr[14:13];
    assign chr_slot = addr[12:10];
    assign product  = mul_a_reg * mul_b_reg;
    assign prg_go   = addr[ADDR_W-1] && (prg_count_reg != '0);
    assign chr_go   = !chr_ram_reg && (addr[ADDR_W-1:13] == '0) && (chr_count_reg != '0);
    assign rsp_free = !rsp_valid_reg || response.ready;

    // PRG bank selection by mode and 8 KiB slot.
    always_comb
    begin
        unique case (prg_mode_reg)
            2'd0:
            begin
                prg_bank = {prg_bank_reg[3][6:2], prg_slot};
            end
            2'd1:
            begin
                if (!prg_slot[1])
                begin
                    prg_bank = prg_bank_reg[1][7] ? {prg_bank_reg[1][6:1], prg_slot[0]} : '0;
                end
                else
                begin
                    prg_bank = {prg_bank_reg[3][6:1], prg_slot[0]};
                end
            end
            2'd2:
            begin
                if (!prg_slot[1])
                begin
                    prg_bank = prg_bank_reg[1][7] ? {prg_bank_reg[1][6:1], prg_slot[0]} : '0;
                end
                else if (!prg_slot[0])
                begin
                    prg_bank = prg_bank_reg[2][7] ? prg_bank_reg[2][6:0] : '0;
                end
                else
                begin
                    prg_bank = prg_bank_reg[3][6:0];
                end
            end
            default:
            begin
                if (prg_slot == 2'd3)
                begin
                    prg_bank = prg_bank_reg[3][6:0];
                end
                else
                begin
                    prg_bank = prg_bank_reg[prg_slot][7] ? prg_bank_reg[prg_slot][6:0] : '0;
                end
            end
        endcase
    end

    // Sprite and background CHR bank selection by mode and 1 KiB slot.
    always_comb
    begin
        unique case (chr_mode_reg)
            2'd0:
            begin
                spr_bank = {spr_bank_reg[7], chr_slot};
                bg_bank  = {1'b0, bg_bank_reg[3], chr_slot[1:0]};
            end
            2'd1:
            begin
                spr_bank = chr_slot[2] ? {1'b0, spr_bank_reg[7], chr_slot[1:0]}
                                       : {1'b0, spr_bank_reg[3], chr_slot[1:0]};
                bg_bank  = {1'b0, bg_bank_reg[3], chr_slot[1:0]};
            end
            2'd2:
            begin
                spr_bank = {2'b00, spr_bank_reg[{chr_slot[2:1], 1'b1}], chr_slot[0]};
                bg_bank  = chr_slot[1] ? {2'b00, bg_bank_reg[3], chr_slot[0]}
                                       : {2'b00, bg_bank_reg[1], chr_slot[0]};
            end
            default:
            begin
                spr_bank = {3'b000, spr_bank_reg[chr_slot]};
                bg_bank  = {3'b000, bg_bank_reg[chr_slot[1:0]]};
            end
        endcase
    end

    // Mirroring code from the nametable select byte.
    always_comb
    begin
        unique case (nt_sel_reg)
            NT_HORIZ:    mirror_code = MIR_HORIZ;
            NT_VERT:     mirror_code = MIR_VERT;
            NT_SINGLE_B: mirror_code = MIR_SINGLE_B;
            default:     mirror_code = MIR_SINGLE_A;
        endcase
    end

    // Remainder unit start.
    always_comb
    begin
        mod_req.start    = 1'b0;
        mod_req.dividend = {4'b0000, prg_bank};
        mod_req.divisor  = {4'b0000, prg_count_reg};
        if (item_reg.operation == OP_CHR)
        begin
            mod_req.dividend = item_reg.background_fetch ? bg_bank : spr_bank;
            mod_req.divisor  = chr_count_reg;
        end
        if (state_reg == ST_EXEC)
        begin
            mod_req.start = ((item_reg.operation == OP_PRG) && prg_go)
                         || ((item_reg.operation == OP_CHR) && chr_go);
        end
    end

    cbm_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = mod_req.start ? ST_DIV : ST_FINISH;
            end
            ST_DIV:
            begin
                if (mod_rsp.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign request.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
        end
    end

    // Request word capture.
    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            item_reg <= request.data;
        end
    end

    // Configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_count_reg <= '0;
            chr_count_reg <= '0;
            chr_ram_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PRG_COUNT: prg_count_reg <= cfg_data[PRG_CNT_W-1:0];
                CFG_CHR_COUNT: chr_count_reg <= cfg_data;
                CFG_CHR_RAM:   chr_ram_reg   <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Expansion RAM port: clearing pass after reset, then register writes.
    always_comb
    begin
        xram_we    = 1'b0;
        xram_waddr = clr_idx_reg;
        xram_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            xram_we = 1'b1;
        end
        else if ((state_reg == ST_EXEC) && (item_reg.operation == OP_WRITE) && xram_hit)
        begin
            xram_we    = 1'b1;
            xram_waddr = addr[XRAM_AW-1:0];
            xram_wdata = item_reg.write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (xram_we)
        begin
            xram[xram_waddr] <= xram_wdata;
        end
        xram_q <= xram[addr[XRAM_AW-1:0]];
    end

    // Register window, scanline IRQ and read side effects.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_mode_reg     <= 2'd3;
            chr_mode_reg     <= 2'd0;
            for (int i = 0; i < 4; i++)
            begin
                prg_bank_reg[i] <= '1;
                bg_bank_reg[i]  <= '0;
            end
            for (int i = 0; i < 8; i++)
            begin
                spr_bank_reg[i] <= '0;
            end
            nt_sel_reg       <= '0;
            mul_a_reg        <= '0;
            mul_b_reg        <= '0;
            irq_line_reg     <= '0;
            irq_enable_reg   <= 1'b0;
            irq_pending_reg  <= 1'b0;
            irq_out_reg      <= 1'b0;
            frame_active_reg <= 1'b0;
        end
        else if (state_reg == ST_EXEC)
        begin
            unique case (item_reg.operation)
                OP_READ:
                begin
                    if (!xram_hit && (addr == A_IRQ_STAT))
                    begin
                        irq_pending_reg <= 1'b0;
                        irq_out_reg     <= 1'b0;
                    end
                end
                OP_WRITE:
                begin
                    if (addr[ADDR_W-1:2] == A_PRG_BANK[ADDR_W-1:2])
                    begin
                        prg_bank_reg[addr[1:0]] <= item_reg.write_data;
                    end
                    else if (addr[ADDR_W-1:3] == A_SPR_BANK[ADDR_W-1:3])
                    begin
                        spr_bank_reg[addr[2:0]] <= item_reg.write_data;
                    end
                    else if (addr[ADDR_W-1:2] == A_BG_BANK[ADDR_W-1:2])
                    begin
                        bg_bank_reg[addr[1:0]] <= item_reg.write_data;
                    end
                    else if (addr == A_PRG_MODE)
                    begin
                        prg_mode_reg <= item_reg.write_data[1:0];
                    end
                    else if (addr == A_CHR_MODE)
                    begin
                        chr_mode_reg <= item_reg.write_data[1:0];
                    end
                    else if (addr == A_NT_SEL)
                    begin
                        nt_sel_reg <= item_reg.write_data;
                    end
                    else if (addr == A_IRQ_LINE)
                    begin
                        irq_line_reg <= item_reg.write_data;
                    end
                    else if (addr == A_IRQ_STAT)
                    begin
                        irq_enable_reg <= item_reg.write_data[7];
                        if (!item_reg.write_data[7])
                        begin
                            irq_out_reg <= 1'b0;
                        end
                    end
                    else if (addr == A_MUL_LO)
                    begin
                        mul_a_reg <= item_reg.write_data;
                    end
                    else if (addr == A_MUL_HI)
                    begin
                        mul_b_reg <= item_reg.write_data;
                    end
                end
                OP_TICK:
                begin
                    if (item_reg.scanline >= FRAME_END)
                    begin
                        frame_active_reg <= 1'b0;
                    end
                    else
                    begin
                        frame_active_reg <= 1'b1;
                        if (item_reg.scanline == {1'b0, irq_line_reg})
                        begin
                            irq_pending_reg <= 1'b1;
                            if (irq_enable_reg)
                            begin
                                irq_out_reg <= 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Read data and translation result registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC)
        begin
            rd_reg        <= '0;
            rom_reg       <= '0;
            rom_valid_reg <= 1'b0;
            if (item_reg.operation == OP_READ)
            begin
                if (addr == A_IRQ_STAT)
                begin
                    rd_reg <= {irq_pending_reg, frame_active_reg, 6'b000000};
                end
                else if (addr == A_MUL_LO)
                begin
                    rd_reg <= product[DATA_W-1:0];
                end
                else if (addr == A_MUL_HI)
                begin
                    rd_reg <= product[2*DATA_W-1:DATA_W];
                end
            end
            else if ((item_reg.operation == OP_CHR) && chr_ram_reg)
            begin
                rom_reg <= {{(ROM_W-ADDR_W){1'b0}}, addr};
            end
        end
        else if ((state_reg == ST_DIV) && mod_rsp.done)
        begin
            rom_valid_reg <= 1'b1;
            if (item_reg.operation == OP_PRG)
            begin
                rom_reg <= {mod_rsp.remainder[PRG_CNT_W-1:0], addr[PRG_OFS_W-1:0]};
            end
            else
            begin
                rom_reg <= {mod_rsp.remainder[BANK_W-1:0], addr[CHR_OFS_W-1:0]};
            end
        end
    end

    // Response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_FINISH) && rsp_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (response.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && rsp_free)
        begin
            rsp_data_reg.read_data   <= ((item_reg.operation == OP_READ) && xram_hit)
                                        ? xram_q : rd_reg;
            rsp_data_reg.irq_line    <= irq_out_reg;
            rsp_data_reg.rom_address <= rom_reg;
            rsp_data_reg.rom_valid   <= rom_valid_reg;
            rsp_data_reg.mirroring   <= mirror_code;
        end
    end

    assign response.valid = rsp_valid_reg;
    assign response.data  = rsp_data_reg;

    // The IRQ line is only raised while enabled and with an IRQ pending.
    a_irq_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        irq_out_reg |-> irq_enable_reg)
        else $error("IRQ line high while IRQ disabled");

    a_irq_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        irq_out_reg |-> irq_pending_reg)
        else $error("IRQ line high with no pending IRQ");

    // The remainder unit only finishes while the sequencer waits for it.
    a_mod_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        mod_rsp.done |-> (state_reg == ST_DIV))
        else $error("Remainder result outside the divide state");

    // No request is taken during the clearing pass.
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !request.ready)
        else $error("Request accepted while clearing expansion RAM");

endmodule

### test/cartridge_bank_mapper_irq_core_test.sv
// Self-checking testbench of the cartridge bank mapper core: random and directed words.
module cartridge_bank_mapper_irq_core_test;
    import cbm_pkg::*;

    // Scoreboard: a behavioral mapper and the queue of predicted response words.
    class mapper_scoreboard;
        int unsigned prg_count;
        int unsigned chr_count;
        bit chr_ram;
        bit [1:0] prg_mode;
        bit [1:0] chr_mode;
        bit [7:0] prg_regs [4];
        bit [7:0] spr_regs [8];
        bit [7:0] bg_regs [4];
        bit [7:0] nt_sel;
        bit [7:0] mul_a;
        bit [7:0] mul_b;
        bit [7:0] irq_target;
        bit irq_en;
        bit irq_pend;
        bit irq_level;
        bit in_frame;
        bit [7:0] xram [XRAM_DEPTH];
        rsp_word_t predicted [$];
        int mismatches;

        function void clear();
            prg_count = 0;
            chr_count = 0;
            chr_ram = 0;
            prg_mode = 3;
            chr_mode = 0;
            foreach (prg_regs[i]) prg_regs[i] = 8'hFF;
            foreach (spr_regs[i]) spr_regs[i] = 0;
            foreach (bg_regs[i]) bg_regs[i] = 0;
            nt_sel = 0;
            mul_a = 0;
            mul_b = 0;
            irq_target = 0;
            irq_en = 0;
            irq_pend = 0;
            irq_level = 0;
            in_frame = 0;
            foreach (xram[i]) xram[i] = 0;
            mismatches = 0;
        endfunction

        function int unsigned rom_bank(bit [7:0] r);
            return r[7] ? int'(r[6:0]) : 0;
        endfunction

        function int unsigned prg_bank(int unsigned slot);
            bit [7:0] r1;
            bit [7:0] r3;
            r1 = prg_regs[1];
            r3 = prg_regs[3];
            case (prg_mode)
                2'd0: return (r3 & 8'h7C) + slot;
                2'd1:
                    if (slot < 2) return r1[7] ? (r1 & 8'h7E) + (slot & 1) : 0;
                    else return (r3 & 8'h7E) + (slot & 1);
                2'd2:
                    if (slot < 2) return r1[7] ? (r1 & 8'h7E) + (slot & 1) : 0;
                    else if (slot == 2) return rom_bank(prg_regs[2]);
                    else return r3 & 8'h7F;
                default:
                    if (slot < 3) return rom_bank(prg_regs[slot]);
                    else return r3 & 8'h7F;
            endcase
        endfunction

        function int unsigned sprite_bank(int unsigned slot);
            case (chr_mode)
                2'd0: return spr_regs[7] * 8 + slot;
                2'd1:
                    if (slot < 4) return spr_regs[3] * 4 + slot;
                    else return spr_regs[7] * 4 + slot - 4;
                2'd2: return spr_regs[(slot & 6) + 1] * 2 + (slot & 1);
                default: return spr_regs[slot];
            endcase
        endfunction

        function int unsigned background_bank(int unsigned slot);
            int unsigned s;
            s = slot & 3;
            case (chr_mode)
                2'd0, 2'd1: return bg_regs[3] * 4 + s;
                2'd2:
                    if (s < 2) return bg_regs[1] * 2 + s;
                    else return bg_regs[3] * 2 + s - 2;
                default: return bg_regs[s];
            endcase
        endfunction

        function void set_config(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_PRG_COUNT: prg_count = v[7:0];
                CFG_CHR_COUNT: chr_count = v;
                CFG_CHR_RAM: chr_ram = v[0];
                default: ;
            endcase
        endfunction

        // Apply one accepted request word and queue the response it causes.
        function void note_request(req_word_t w);
            rsp_word_t r;
            bit [15:0] a;
            int unsigned bank;
            bit [15:0] product;
            r = '0;
            a = w.address;
            product = mul_a * mul_b;
            case (w.operation)
                OP_READ:
                    if (a >= A_XRAM_BASE) begin
                        if (a <= 16'h5FFF) r.read_data = xram[a - A_XRAM_BASE];
                    end
                    else if (a == A_IRQ_STAT) begin
                        r.read_data = {irq_pend, in_frame, 6'd0};
                        irq_pend = 0;
                        irq_level = 0;
                    end
                    else if (a == A_MUL_LO) r.read_data = product[7:0];
                    else if (a == A_MUL_HI) r.read_data = product[15:8];
                OP_WRITE:
                    if (a >= A_XRAM_BASE && a <= 16'h5FFF) xram[a - A_XRAM_BASE] = w.write_data;
                    else if (a >= A_PRG_BANK && a <= A_PRG_BANK + 3)
                        prg_regs[a - A_PRG_BANK] = w.write_data;
                    else if (a >= A_SPR_BANK && a <= A_SPR_BANK + 7)
                        spr_regs[a - A_SPR_BANK] = w.write_data;
                    else if (a >= A_BG_BANK && a <= A_BG_BANK + 3)
                        bg_regs[a - A_BG_BANK] = w.write_data;
                    else if (a == A_PRG_MODE) prg_mode = w.write_data[1:0];
                    else if (a == A_CHR_MODE) chr_mode = w.write_data[1:0];
                    else if (a == A_NT_SEL) nt_sel = w.write_data;
                    else if (a == A_IRQ_LINE) irq_target = w.write_data;
                    else if (a == A_IRQ_STAT) begin
                        irq_en = w.write_data[7];
                        if (!irq_en) irq_level = 0;
                    end
                    else if (a == A_MUL_LO) mul_a = w.write_data;
                    else if (a == A_MUL_HI) mul_b = w.write_data;
                OP_TICK:
                    if (w.scanline >= FRAME_END) in_frame = 0;
                    else begin
                        in_frame = 1;
                        if (w.scanline == irq_target) begin
                            irq_pend = 1;
                            if (irq_en) irq_level = 1;
                        end
                    end
                OP_PRG:
                    if (a[15] && prg_count != 0) begin
                        bank = prg_bank(a[14:13]) % prg_count;
                        r.rom_address = bank * 8192 + a[12:0];
                        r.rom_valid = 1;
                    end
                OP_CHR:
                    if (chr_ram) r.rom_address = a;
                    else if (a < 16'h2000 && chr_count != 0) begin
                        bank = w.background_fetch ? background_bank(a[12:10])
                                                  : sprite_bank(a[12:10]);
                        r.rom_address = (bank % chr_count) * 1024 + a[9:0];
                        r.rom_valid = 1;
                    end
                default: ;
            endcase
            r.irq_line = irq_level;
            case (nt_sel)
                NT_HORIZ: r.mirroring = MIR_HORIZ;
                NT_VERT: r.mirroring = MIR_VERT;
                NT_SINGLE_B: r.mirroring = MIR_SINGLE_B;
                default: r.mirroring = MIR_SINGLE_A;
            endcase
            predicted.push_back(r);
        endfunction

        // Compare one accepted response word with the oldest prediction.
        function void check_response(rsp_word_t got);
            rsp_word_t exp_w;
            if (predicted.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected response word %h", got);
                return;
            end
            exp_w = predicted.pop_front();
            if (got !== exp_w) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Response mismatch: rd %h/%h irq %b/%b rom %h/%h v %b/%b mir %d/%d",
                        exp_w.read_data, got.read_data, exp_w.irq_line, got.irq_line,
                        exp_w.rom_address, got.rom_address, exp_w.rom_valid, got.rom_valid,
                        exp_w.mirroring, got.mirroring);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int no_stall_phase;

    cbm_req_if request ();
    cbm_rsp_if response ();
    mapper_scoreboard board;

    cartridge_bank_mapper_irq_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .request(request),
        .response(response)
    );

    initial clk = 0;
    always #10 clk = ~clk;

    // Gap drawn per word; some phases run without gaps.
    function int draw_gap();
        return no_stall_phase ? 0 : $urandom_range(0, 14);
    endfunction

    // Offer one request word and wait until it is accepted. With no gap the
    // next word follows at once, so valid stays high.
    task send_word(req_word_t w);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            request.valid <= 0;
            repeat (gap) @(negedge clk);
        end
        request.valid <= 1;
        request.data <= w;
        @(posedge clk);
        while (!request.ready) @(posedge clk);
        board.note_request(w);
        @(negedge clk);
    endtask

    task write_config(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] v);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 0;
        board.set_config(idx, v);
        @(negedge clk);
    endtask

    // Let every predicted response drain before touching configuration.
    task drain();
        request.valid <= 0;
        while (board.predicted.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function req_word_t make_word(bit [2:0] op, bit [15:0] a, bit [7:0] d = 0,
                                  bit [8:0] line = 0, bit bg = 0);
        req_word_t w;
        w.operation = op;
        w.address = a;
        w.write_data = d;
        w.scanline = line;
        w.background_fetch = bg;
        return w;
    endfunction

    // Random word, weighted toward meaningful register traffic and translations.
    function req_word_t random_word();
        req_word_t w;
        int pick;
        bit [15:0] regs [16];
        bit [7:0] nt_codes [3];
        regs = '{A_PRG_MODE, A_CHR_MODE, A_NT_SEL, A_IRQ_LINE, A_IRQ_STAT, A_MUL_LO,
                 A_MUL_HI, A_PRG_BANK, 16'(A_PRG_BANK + 1), 16'(A_PRG_BANK + 2),
                 16'(A_PRG_BANK + 3), 16'(A_SPR_BANK + $urandom_range(0, 7)),
                 16'(A_BG_BANK + $urandom_range(0, 3)),
                 16'(16'h5000 + $urandom_range(0, 16'h15)), A_IRQ_STAT, A_MUL_HI};
        nt_codes = '{NT_HORIZ, NT_VERT, NT_SINGLE_B};
        w.operation = OP_READ;
        w.address = 16'($urandom);
        w.write_data = 8'($urandom);
        w.scanline = 9'($urandom);
        w.background_fetch = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 5) w.operation = 3'($urandom_range(5, 7));
        else if (pick < 20) begin
            w.operation = OP_WRITE;
            if ($urandom_range(0, 3) == 0)
                w.address = 16'(A_XRAM_BASE + $urandom_range(0, 1023));
            else if ($urandom_range(0, 9) == 0) w.address = 16'($urandom);
            else w.address = regs[$urandom_range(0, 15)];
            if (w.address == A_NT_SEL && $urandom_range(0, 1))
                w.write_data = nt_codes[$urandom_range(0, 2)];
        end
        else if (pick < 32) begin
            w.operation = OP_READ;
            if ($urandom_range(0, 2) == 0)
                w.address = 16'(A_XRAM_BASE + $urandom_range(0, 1023));
            else if ($urandom_range(0, 5) == 0) w.address = 16'($urandom);
            else w.address = 16'(A_IRQ_STAT + $urandom_range(0, 2));
        end
        else if (pick < 50) begin
            w.operation = OP_TICK;
            if ($urandom_range(0, 1)) w.scanline = 9'($urandom_range(0, 8));
        end
        else if (pick < 72) begin
            w.operation = OP_PRG;
            if ($urandom_range(0, 7) != 0) w.address[15] = 1;
        end
        else begin
            w.operation = OP_CHR;
            if ($urandom_range(0, 7) != 0) w.address[15:13] = 0;
        end
        return w;
    endfunction

    // Response side: random stalls, checked on acceptance.
    initial begin
        int gap;
        response.ready = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            gap = draw_gap();
            if (gap > 0) begin
                response.ready <= 0;
                repeat (gap) @(negedge clk);
            end
            response.ready <= 1;
            @(posedge clk);
            while (!response.valid) @(posedge clk);
            board.check_response(response.data);
        end
    end

    // Stimulus.
    initial begin
        bit [CFG_DATA_W-1:0] prg_settings [5];
        bit [CFG_DATA_W-1:0] chr_settings [5];
        board = new();
        board.clear();
        rst_n = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        request.valid = 0;
        request.data = '0;
        no_stall_phase = 0;
        repeat (11) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed words: reset state, register extremes, IRQ path and mirroring.
        write_config(CFG_PRG_COUNT, 128);
        write_config(CFG_CHR_COUNT, 2048);
        write_config(CFG_CHR_RAM, 0);
        send_word(make_word(OP_READ, 16'h5FFF));
        send_word(make_word(OP_PRG, 16'hFFFF));
        send_word(make_word(OP_PRG, 16'h7FFF));
        send_word(make_word(OP_CHR, 16'h1FFF, 0, 0, 1));
        send_word(make_word(OP_CHR, 16'h2000));
        send_word(make_word(OP_WRITE, A_XRAM_BASE, 8'hFF));
        send_word(make_word(OP_READ, A_XRAM_BASE));
        send_word(make_word(OP_WRITE, A_MUL_LO, 8'hFF));
        send_word(make_word(OP_WRITE, A_MUL_HI, 8'hFF));
        send_word(make_word(OP_READ, A_MUL_LO));
        send_word(make_word(OP_READ, A_MUL_HI));
        send_word(make_word(OP_WRITE, A_IRQ_LINE, 8'd5));
        send_word(make_word(OP_TICK, 0, 0, 9'd5));
        send_word(make_word(OP_WRITE, A_IRQ_STAT, 8'h80));
        send_word(make_word(OP_TICK, 0, 0, 9'd5));
        send_word(make_word(OP_READ, A_IRQ_STAT));
        send_word(make_word(OP_TICK, 0, 0, 9'd511));
        send_word(make_word(OP_READ, A_IRQ_STAT));
        send_word(make_word(OP_WRITE, A_NT_SEL, NT_VERT));
        send_word(make_word(OP_WRITE, A_PRG_BANK + 1, 8'h7F));
        send_word(make_word(OP_WRITE, A_PRG_MODE, 8'h01));
        send_word(make_word(OP_PRG, 16'h8000));
        send_word(make_word(OP_WRITE, A_CHR_MODE, 8'h03));
        send_word(make_word(OP_CHR, 16'h0400));
        send_word(make_word(7, 16'hFFFF, 8'hFF, 9'h1FF, 1));

        // Random phases over several configurations, extremes included.
        prg_settings = '{0, 1, 128, 255, 7};
        chr_settings = '{0, 1, 2048, 4095, 13};
        for (int phase = 0; phase < 10; phase++) begin
            drain();
            write_config(CFG_PRG_COUNT, phase < 5 ? prg_settings[phase] : $urandom_range(1, 255));
            write_config(CFG_CHR_COUNT, phase < 5 ? chr_settings[phase] : $urandom_range(1, 4095));
            write_config(CFG_CHR_RAM, phase == 3 || phase == 7);
            no_stall_phase = (phase == 4 || phase == 8);
            for (int n = 0; n < 163; n++) send_word(random_word());
        end
        drain();
        if (board.mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    // Watchdog.
    initial begin
        #(20 * 3000000);
        $display("Mismatches found");
        $finish;
    end
endmodule

### cartridge_bank_mapper_irq_core.f
hdl/cbm_pkg.sv
hdl/cbm_if.sv
hdl/cbm_mod.sv
hdl/cartridge_bank_mapper_irq_core.sv
test/cartridge_bank_mapper_irq_core_test.sv
